FILE: hdl/csc_pkg.sv
// Package: shared codes and control types for the cell sphere classifier.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Z    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TEST_MODE   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_SELECT = 3'd5;

    // Test modes; the unused code behaves as ball
    localparam logic [1:0] MODE_CROSS = 2'd0;
    localparam logic [1:0] MODE_BALL  = 2'd1;
    localparam logic [1:0] MODE_CYL   = 2'd2;

    // Cylinder axes; the unused code drops no coordinate
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] axis;
    } t_ctrl;

endpackage

`default_nettype wire

FILE: hdl/csc_in_if.sv
// Interface: vertex input channel.
`timescale 1ns / 1ps
`default_nettype none

interface csc_in_if #(
    parameter int COORD_BITS      = 24,
    parameter int CELL_INDEX_BITS = 20
);
    logic                        valid;
    logic                        ready;
    logic [CELL_INDEX_BITS-1:0]  cell_index;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic                        last_vertex;

    modport source (output valid, cell_index, vertex_x, vertex_y, vertex_z, last_vertex,
                    input ready);
    modport sink   (input valid, cell_index, vertex_x, vertex_y, vertex_z, last_vertex,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/csc_out_if.sv
// Interface: classified cell output channel.
`timescale 1ns / 1ps
`default_nettype none

interface csc_out_if #(
    parameter int CELL_INDEX_BITS = 20
);
    logic                       valid;
    logic                       ready;
    logic [CELL_INDEX_BITS-1:0] cell_out;
    logic                       selected;

    modport source (output valid, cell_out, selected, input ready);
    modport sink   (input valid, cell_out, selected, output ready);
endinterface

`default_nettype wire

FILE: hdl/cell_sphere_classifier.sv
// Top level: classifies mesh cells against a sphere or cylinder, vertex by vertex.
//
//   channel  | direction | beat carries
//   ---------+-----------+--------------------------------------------------
//   i_vtx    | in        | cell_index, vertex_x/y/z, last_vertex
//   o_cell   | out       | cell_out, selected (one beat per marked vertex)
//   i_cfg_*  | in        | register index and data, written on i_cfg_we
//
// One vertex a cycle unless a marked vertex is held; two register stages
// (squares, then sum, compare and the output register) separate vertex beat
// and cell beat. The three squaring multipliers in the first stage set the
// cycle time. Synchronous active-low reset clears the pipeline valids, the
// cell flags and the configuration to its defaults. A stalled output holds
// only marked vertices; earlier unmarked vertices flow into the cell flags.
`timescale 1ns / 1ps
`default_nettype none

module cell_sphere_classifier
    import csc_pkg::*;
#(
    parameter int COORD_BITS      = 24,
    parameter int CELL_INDEX_BITS = 20
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [COORD_BITS-1:0]     i_cfg_data,
    csc_in_if.sink                         i_vtx,
    csc_out_if.source                      o_cell
);
    localparam int SW = 2 * COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] w_cx, w_cy, w_cz;
    logic [2*COORD_BITS-3:0]      w_r2;
    t_ctrl                        w_ctrl;

    logic                       w_a_valid, w_a_last, w_adv;
    logic [CELL_INDEX_BITS-1:0] w_a_cell;
    logic [SW-1:0]              w_sq_x, w_sq_y, w_sq_z;

    csc_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (i_cfg_we),
        .i_index    (i_cfg_index),
        .i_data     (i_cfg_data),
        .o_center_x (w_cx),
        .o_center_y (w_cy),
        .o_center_z (w_cz),
        .o_r2       (w_r2),
        .o_ctrl     (w_ctrl)
    );

    csc_square #(
        .COORD_BITS      (COORD_BITS),
        .CELL_INDEX_BITS (CELL_INDEX_BITS)
    ) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vtx.valid),
        .o_ready (i_vtx.ready),
        .i_cell  (i_vtx.cell_index),
        .i_vx    (i_vtx.vertex_x),
        .i_vy    (i_vtx.vertex_y),
        .i_vz    (i_vtx.vertex_z),
        .i_last  (i_vtx.last_vertex),
        .i_cx    (w_cx),
        .i_cy    (w_cy),
        .i_cz    (w_cz),
        .i_ctrl  (w_ctrl),
        .i_adv   (w_adv),
        .o_valid (w_a_valid),
        .o_cell  (w_a_cell),
        .o_last  (w_a_last),
        .o_sq_x  (w_sq_x),
        .o_sq_y  (w_sq_y),
        .o_sq_z  (w_sq_z)
    );

    csc_classify #(
        .COORD_BITS      (COORD_BITS),
        .CELL_INDEX_BITS (CELL_INDEX_BITS)
    ) u_classify (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_a_valid),
        .o_adv      (w_adv),
        .i_cell     (w_a_cell),
        .i_last     (w_a_last),
        .i_sq_x     (w_sq_x),
        .i_sq_y     (w_sq_y),
        .i_sq_z     (w_sq_z),
        .i_r2       (w_r2),
        .i_ctrl     (w_ctrl),
        .o_valid    (o_cell.valid),
        .i_ready    (o_cell.ready),
        .o_cell     (o_cell.cell_out),
        .o_selected (o_cell.selected)
    );

endmodule

`default_nettype wire

FILE: hdl/csc_cfg_regs.sv
// Configuration register file with registered radius squared.
`timescale 1ns / 1ps
`default_nettype none

module csc_cfg_regs
    import csc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_we,
    input  wire logic [CFG_INDEX_BITS-1:0]    i_index,
    input  wire logic [COORD_BITS-1:0]        i_data,
    output logic signed [COORD_BITS-1:0]      o_center_x,
    output logic signed [COORD_BITS-1:0]      o_center_y,
    output logic signed [COORD_BITS-1:0]      o_center_z,
    output logic [2*COORD_BITS-3:0]           o_r2,
    output t_ctrl                             o_ctrl
);
    localparam int RAD_W = COORD_BITS - 1;
    localparam int R2_W  = 2 * COORD_BITS - 2;

    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_cz;
    logic [RAD_W-1:0]             r_radius;
    logic [R2_W-1:0]              r_r2;
    t_ctrl                        r_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx        <= '0;
            r_cy        <= '0;
            r_cz        <= '0;
            r_radius    <= '0;
            r_r2        <= '0;
            r_ctrl.mode <= MODE_CROSS;
            r_ctrl.axis <= AXIS_Z;
        end else begin
            // Registered from the radius; users must let writes land only while idle, the block does not enforce it
            r_r2 <= R2_W'(r_radius) * R2_W'(r_radius);
            if (i_we) begin
                unique case (i_index)
                    REG_CENTER_X:    r_cx        <= i_data;
                    REG_CENTER_Y:    r_cy        <= i_data;
                    REG_CENTER_Z:    r_cz        <= i_data;
                    REG_RADIUS:      r_radius    <= i_data[RAD_W-1:0];
                    REG_TEST_MODE:   r_ctrl.mode <= i_data[1:0];
                    REG_AXIS_SELECT: r_ctrl.axis <= i_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_center_x = r_cx;
    assign o_center_y = r_cy;
    assign o_center_z = r_cz;
    assign o_r2       = r_r2;
    assign o_ctrl     = r_ctrl;

endmodule

`default_nettype wire

FILE: hdl/csc_square.sv
// First stage: per-axis distance magnitudes and their exact squares.
`timescale 1ns / 1ps
`default_nettype none

module csc_square
    import csc_pkg::*;
#(
    parameter int COORD_BITS      = 24,
    parameter int CELL_INDEX_BITS = 20
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [CELL_INDEX_BITS-1:0]    i_cell,
    input  wire logic signed [COORD_BITS-1:0]  i_vx,
    input  wire logic signed [COORD_BITS-1:0]  i_vy,
    input  wire logic signed [COORD_BITS-1:0]  i_vz,
    input  wire logic                          i_last,
    input  wire logic signed [COORD_BITS-1:0]  i_cx,
    input  wire logic signed [COORD_BITS-1:0]  i_cy,
    input  wire logic signed [COORD_BITS-1:0]  i_cz,
    input  wire t_ctrl                         i_ctrl,
    input  wire logic                          i_adv,
    output logic                               o_valid,
    output logic [CELL_INDEX_BITS-1:0]         o_cell,
    output logic                               o_last,
    output logic [2*COORD_BITS+1:0]            o_sq_x,
    output logic [2*COORD_BITS+1:0]            o_sq_y,
    output logic [2*COORD_BITS+1:0]            o_sq_z
);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * DW;

    logic signed [DW-1:0] n_dx, n_dy, n_dz;
    logic [DW-1:0]        n_mx, n_my, n_mz;
    logic [SW-1:0]        n_sx, n_sy, n_sz;
    logic                 n_cyl;

    logic                       r_valid;
    logic [CELL_INDEX_BITS-1:0] r_cell;
    logic                       r_last;
    logic [SW-1:0]              r_sx, r_sy, r_sz;

    always_comb begin
        n_dx = DW'(i_cx) - DW'(i_vx);
        n_dy = DW'(i_cy) - DW'(i_vy);
        n_dz = DW'(i_cz) - DW'(i_vz);
        n_mx = n_dx[DW-1] ? DW'(-n_dx) : DW'(n_dx);
        n_my = n_dy[DW-1] ? DW'(-n_dy) : DW'(n_dy);
        n_mz = n_dz[DW-1] ? DW'(-n_dz) : DW'(n_dz);
        n_cyl = (i_ctrl.mode == MODE_CYL);
        // Drop the axis coordinate in cylinder mode
        n_sx = (n_cyl && i_ctrl.axis == AXIS_X) ? '0 : SW'(n_mx) * SW'(n_mx);
        n_sy = (n_cyl && i_ctrl.axis == AXIS_Y) ? '0 : SW'(n_my) * SW'(n_my);
        n_sz = (n_cyl && i_ctrl.axis == AXIS_Z) ? '0 : SW'(n_mz) * SW'(n_mz);
    end

    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cell <= i_cell;
            r_last <= i_last;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_sz   <= n_sz;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;
    assign o_last  = r_last;
    assign o_sq_x  = r_sx;
    assign o_sq_y  = r_sy;
    assign o_sq_z  = r_sz;

endmodule

`default_nettype wire

FILE: hdl/csc_classify.sv
// Second stage: sum and compare, cell flags and the output register.
`timescale 1ns / 1ps
`default_nettype none

module csc_classify
    import csc_pkg::*;
#(
    parameter int COORD_BITS      = 24,
    parameter int CELL_INDEX_BITS = 20
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_adv,
    input  wire logic [CELL_INDEX_BITS-1:0]   i_cell,
    input  wire logic                         i_last,
    input  wire logic [2*COORD_BITS+1:0]      i_sq_x,
    input  wire logic [2*COORD_BITS+1:0]      i_sq_y,
    input  wire logic [2*COORD_BITS+1:0]      i_sq_z,
    input  wire logic [2*COORD_BITS-3:0]      i_r2,
    input  wire t_ctrl                        i_ctrl,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [CELL_INDEX_BITS-1:0]        o_cell,
    output logic                              o_selected
);
    localparam int SUM_W = 2 * COORD_BITS + 4;

    logic [SUM_W-1:0] n_sum;
    logic             n_inside;
    logic             n_seen_in, n_seen_out, n_sel;
    logic             n_take;

    logic                       r_seen_in, r_seen_out;
    logic                       r_o_valid;
    logic [CELL_INDEX_BITS-1:0] r_o_cell;
    logic                       r_o_sel;

    always_comb begin
        n_sum      = SUM_W'(i_sq_x) + SUM_W'(i_sq_y) + SUM_W'(i_sq_z);
        n_inside   = n_sum < SUM_W'(i_r2);
        n_seen_in  = r_seen_in || n_inside;
        n_seen_out = r_seen_out || !n_inside;
        n_sel      = (i_ctrl.mode == MODE_CROSS) ? (n_seen_in && n_seen_out) : n_seen_in;
        n_take     = !r_o_valid || i_ready;
    end

    // Unmarked vertices never wait on the output side
    assign o_adv = i_valid && (!i_last || n_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_in  <= 1'b0;
            r_seen_out <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_adv) begin
                // Clear after the marked vertex
                r_seen_in  <= n_seen_in && !i_last;
                r_seen_out <= n_seen_out && !i_last;
            end
            if (n_take) begin
                r_o_valid <= o_adv && i_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take && o_adv && i_last) begin
            r_o_cell <= i_cell;
            r_o_sel  <= n_sel;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_cell     = r_o_cell;
    assign o_selected = r_o_sel;

endmodule

`default_nettype wire

FILE: test/cell_sphere_classifier_tb.sv
// Testbench for the cell sphere classifier: random and directed vertex streams, scoreboarded.
`timescale 1ns / 1ps

module cell_sphere_classifier_tb;
    import csc_pkg::*;

    localparam int COORD_BITS      = 24;
    localparam int CELL_INDEX_BITS = 20;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_ROUND = 45;
    localparam int ROUNDS_PER_PHASE = 5;

    localparam logic signed [COORD_BITS-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_BITS-1:0] C_MIN = 24'sh800000;
    localparam logic [COORD_BITS-2:0]        R_MAX = 23'h7FFFFF;
    // spare codes: the mode acts as ball, the axis drops nothing
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [1:0] AXIS_NONE  = 2'd3;

    typedef longint unsigned t_u64;

    typedef struct {
        logic [CELL_INDEX_BITS-1:0] cell_idx;
        logic                       sel;
    } t_cell_result;

    class cell_scoreboard;
        logic signed [COORD_BITS-1:0] centre_x, centre_y, centre_z;
        logic [COORD_BITS-2:0]        radius;
        logic [1:0]                   mode, axis;
        bit                           seen_in, seen_out;
        t_cell_result                 expected_cells[$];
        int                           errors;
        int                           cells_checked;

        function new();
            centre_x = '0;
            centre_y = '0;
            centre_z = '0;
            radius   = '0;
            mode     = MODE_CROSS;
            axis     = AXIS_Z;
            seen_in  = 1'b0;
            seen_out = 1'b0;
            errors   = 0;
            cells_checked = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [COORD_BITS-1:0] data);
            case (idx)
                REG_CENTER_X:    centre_x = data;
                REG_CENTER_Y:    centre_y = data;
                REG_CENTER_Z:    centre_z = data;
                REG_RADIUS:      radius   = data[COORD_BITS-2:0];
                REG_TEST_MODE:   mode     = data[1:0];
                REG_AXIS_SELECT: axis     = data[1:0];
                default: ;
            endcase
        endfunction

        // exact square of one coordinate offset; the cylinder axis contributes nothing
        function t_u64 squared_offset(logic signed [COORD_BITS-1:0] c,
                                      logic signed [COORD_BITS-1:0] v, logic [1:0] ax);
            longint d;
            t_u64   m;
            d = longint'(c) - longint'(v);
            if (d < 0) d = -d;
            if (mode == MODE_CYL && axis == ax) return 0;
            m = d;
            return m * m;
        endfunction

        function void note_vertex(logic [CELL_INDEX_BITS-1:0] idx,
                                  logic signed [COORD_BITS-1:0] x,
                                  logic signed [COORD_BITS-1:0] y,
                                  logic signed [COORD_BITS-1:0] z, logic last);
            t_u64         dist2, r, r2;
            t_cell_result res;
            dist2 = squared_offset(centre_x, x, AXIS_X) + squared_offset(centre_y, y, AXIS_Y)
                  + squared_offset(centre_z, z, AXIS_Z);
            r  = radius;
            r2 = r * r;
            if (dist2 < r2) seen_in = 1'b1;
            else seen_out = 1'b1;
            if (last) begin
                res.cell_idx = idx;
                res.sel      = (mode == MODE_CROSS) ? (seen_in && seen_out) : seen_in;
                expected_cells.insert(expected_cells.size(), res);
                seen_in  = 1'b0;
                seen_out = 1'b0;
            end
        endfunction

        function void check_cell(logic [CELL_INDEX_BITS-1:0] idx, logic sel);
            t_cell_result exp_res;
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected cell beat: cell_out %0d selected %0b", $time, idx, sel);
                errors++;
                return;
            end
            exp_res = expected_cells.pop_front();
            cells_checked++;
            if (idx !== exp_res.cell_idx) begin
                $display("%0t: cell_out wrong: expected %0d, actual %0d",
                         $time, exp_res.cell_idx, idx);
                errors++;
            end
            if (sel !== exp_res.sel) begin
                $display("%0t: selected wrong for cell %0d: expected %0b, actual %0b",
                         $time, exp_res.cell_idx, exp_res.sel, sel);
                errors++;
            end
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [COORD_BITS-1:0]     i_cfg_data;

    csc_in_if  #(.COORD_BITS(COORD_BITS), .CELL_INDEX_BITS(CELL_INDEX_BITS)) vtx ();
    csc_out_if #(.CELL_INDEX_BITS(CELL_INDEX_BITS)) cells ();

    cell_sphere_classifier #(
        .COORD_BITS      (COORD_BITS),
        .CELL_INDEX_BITS (CELL_INDEX_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_vtx       (vtx),
        .o_cell      (cells)
    );

    cell_scoreboard sb;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  vertex_beats = 0;
    int  settings_used = 0;
    bit  hold_req = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cells.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            cells.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            cells.ready <= 1'b0;
        end else begin
            cells.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && vtx.valid && vtx.ready) begin
            sb.note_vertex(vtx.cell_index, vtx.vertex_x, vtx.vertex_y, vtx.vertex_z,
                           vtx.last_vertex);
            vertex_beats <= vertex_beats + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cells.valid && cells.ready) begin
            sb.check_cell(cells.cell_out, cells.selected);
        end
    end

    task automatic send_vertex(input logic [CELL_INDEX_BITS-1:0] idx,
                               input logic signed [COORD_BITS-1:0] x,
                               input logic signed [COORD_BITS-1:0] y,
                               input logic signed [COORD_BITS-1:0] z, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            vtx.valid <= 1'b0;
            @(posedge i_clk);
        end
        vtx.valid       <= 1'b1;
        vtx.cell_index  <= idx;
        vtx.vertex_x    <= x;
        vtx.vertex_y    <= y;
        vtx.vertex_z    <= z;
        vtx.last_vertex <= last;
        do @(posedge i_clk); while (!vtx.ready);
    endtask

    // drop valid and wait until every cell beat is in and the pipeline is empty
    task automatic settle_pipeline();
        vtx.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_setting(input logic signed [COORD_BITS-1:0] cx,
                                   input logic signed [COORD_BITS-1:0] cy,
                                   input logic signed [COORD_BITS-1:0] cz,
                                   input logic [COORD_BITS-2:0] rad,
                                   input logic [1:0] mode, input logic [1:0] axis);
        logic [CFG_INDEX_BITS-1:0] idx [6];
        logic [COORD_BITS-1:0]     val [6];
        idx = '{REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z, REG_RADIUS, REG_TEST_MODE,
                REG_AXIS_SELECT};
        val = '{cx, cy, cz, {1'b0, rad}, {22'd0, mode}, {22'd0, axis}};
        settle_pipeline();
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            sb.set_reg(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_centre();
        case ($urandom_range(9))
            0: return C_MIN;
            1: return C_MAX;
            2, 3: return COORD_BITS'($urandom_range(8191)) - 4096;
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [COORD_BITS-2:0] pick_radius();
        case ($urandom_range(9))
            0: return '0;
            1: return R_MAX;
            2, 3, 4, 5: return (COORD_BITS-1)'($urandom_range(1, 65535));
            default: return (COORD_BITS-1)'($urandom);
        endcase
    endfunction

    // coordinate scattered around the centre so that cells straddle the surface
    function automatic logic signed [COORD_BITS-1:0] near_coord(
            logic signed [COORD_BITS-1:0] c);
        longint span;
        longint off;
        if ($urandom_range(9) == 0) return COORD_BITS'($urandom);
        span = sb.radius;
        span = span + span / 2;
        off  = longint'($urandom_range(2 * span)) - span;
        return COORD_BITS'(c + off);
    endfunction

    task automatic send_random_cell(output int n);
        logic [CELL_INDEX_BITS-1:0] idx;
        n = ($urandom_range(9) < 7) ? 8 : $urandom_range(1, 12);
        for (int k = 1; k <= n; k++) begin
            idx = CELL_INDEX_BITS'($urandom);
            send_vertex(idx, near_coord(sb.centre_x), near_coord(sb.centre_y),
                        near_coord(sb.centre_z), k == n);
        end
    endtask

    task automatic run_directed();
        // reset setting: zero radius, so even the centre is not inside
        send_vertex(20'd0, 24'sd0, 24'sd0, 24'sd0, 1'b1);
        program_setting(24'sd0, 24'sd0, 24'sd0, 23'd4096, MODE_CROSS, AXIS_Z);
        // on the surface counts as outside, just within as inside
        send_vertex(20'h12345, 24'sd4096, 24'sd0, 24'sd0, 1'b0);
        send_vertex(20'd1, 24'sd4095, 24'sd0, 24'sd0, 1'b1);
        send_vertex(20'd2, 24'sd0, 24'sd0, 24'sd0, 1'b1);
        send_vertex(20'd0, C_MIN, C_MIN, C_MIN, 1'b0);
        send_vertex(20'hFFFFF, C_MAX, C_MAX, C_MAX, 1'b1);
        program_setting(24'sd0, 24'sd0, 24'sd0, 23'd4096, MODE_BALL, AXIS_Z);
        send_vertex(20'd3, 24'sd0, 24'sd0, 24'sd4095, 1'b1);
        send_vertex(20'd4, 24'sd0, -24'sd4096, 24'sd0, 1'b1);
        // leave a cell open across a mode change
        send_vertex(20'd5, 24'sd0, 24'sd0, 24'sd100, 1'b0);
        program_setting(24'sd0, 24'sd0, 24'sd0, 23'd4096, MODE_CROSS, AXIS_Z);
        send_vertex(20'd5, C_MAX, 24'sd0, 24'sd0, 1'b1);
        program_setting(24'sd0, 24'sd0, 24'sd0, 23'd4096, MODE_CYL, AXIS_Z);
        send_vertex(20'd6, 24'sd0, 24'sd0, C_MAX, 1'b1);
        program_setting(24'sd0, 24'sd0, 24'sd0, 23'd4096, MODE_CYL, AXIS_X);
        send_vertex(20'd7, C_MIN, 24'sd0, 24'sd0, 1'b1);
        send_vertex(20'd8, 24'sd0, 24'sd0, C_MAX, 1'b1);
        program_setting(24'sd0, 24'sd0, 24'sd0, 23'd4096, MODE_CYL, AXIS_Y);
        send_vertex(20'd9, 24'sd0, C_MAX, 24'sd0, 1'b1);
        program_setting(24'sd0, 24'sd0, 24'sd0, 23'd4096, MODE_CYL, AXIS_NONE);
        send_vertex(20'd10, 24'sd0, 24'sd0, C_MAX, 1'b1);
        program_setting(24'sd0, 24'sd0, 24'sd0, 23'd4096, MODE_SPARE, AXIS_Z);
        send_vertex(20'd11, 24'sd10, 24'sd10, 24'sd10, 1'b1);
        program_setting(C_MIN, C_MAX, C_MIN, R_MAX, MODE_BALL, AXIS_Z);
        send_vertex(20'd12, C_MAX, C_MIN, C_MAX, 1'b1);
        send_vertex(20'd13, C_MIN, C_MAX, C_MIN, 1'b1);
    endtask

    task automatic run_phase(input int idle, input int stall, input bit with_hold);
        int sent;
        int n;
        for (int round = 0; round < ROUNDS_PER_PHASE; round++) begin
            program_setting(pick_centre(), pick_centre(), pick_centre(), pick_radius(),
                            2'($urandom_range(3)), 2'($urandom_range(3)));
            idle_pct  = idle;
            stall_pct = stall;
            // stop the receiver for a long stretch while beats keep coming
            if (with_hold && round == 2) hold_req <= ~hold_req;
            sent = 0;
            while (sent < ITEMS_PER_ROUND) begin
                send_random_cell(n);
                sent += n;
            end
            idle_pct  = 0;
            stall_pct = 0;
        end
    endtask

    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_CENTER_X;
        i_cfg_data      <= '0;
        vtx.valid       <= 1'b0;
        vtx.cell_index  <= '0;
        vtx.vertex_x    <= '0;
        vtx.vertex_y    <= '0;
        vtx.vertex_z    <= '0;
        vtx.last_vertex <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_phase(0, 0, 1'b1);
        run_phase(83, 0, 1'b0);
        run_phase(0, 83, 1'b0);
        run_phase(10, 10, 1'b0);
        settle_pipeline();

        $display("Covered %0d vertex beats and %0d classified cells under %0d register settings,",
                 vertex_beats, sb.cells_checked, settings_used);
        $display("with idle and stall phases on both channels and one long output hold-off.");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: cell_sphere_classifier.f
hdl/csc_pkg.sv
hdl/csc_in_if.sv
hdl/csc_out_if.sv
hdl/csc_cfg_regs.sv
hdl/csc_square.sv
hdl/csc_classify.sv
hdl/cell_sphere_classifier.sv
test/cell_sphere_classifier_tb.sv
